// ===== sv/mi3_pkg.sv =====
// Shared widths, types and the cofactor index table for the 3x3 matrix inverse.
`timescale 1ns / 1ps
package mi3_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int N_ELEM    = 9;

	localparam int PROD_W = 2 * WORD_BITS;
	localparam int ADJ_W  = 2 * WORD_BITS + 1;
	localparam int AMAG_W = 2 * WORD_BITS;
	localparam int DET_W  = 3 * WORD_BITS + 1;
	localparam int DMAG_W = 3 * WORD_BITS;
	localparam int LO_W   = WORD_BITS;
	localparam int HI_W   = ADJ_W - LO_W;
	localparam int PP_W   = 2 * WORD_BITS + 1;
	// twice the scaled numerator magnitude: |adj| * 2^(2*FRAC_BITS+1)
	localparam int NUM_W  = AMAG_W + 2 * FRAC_BITS + 1;
	// quotient bits of floor(2N/D), one above the saturation point
	localparam int Q_W    = WORD_BITS + 2;
	localparam int CMP_W  = DMAG_W + Q_W;

	localparam int IN_BITS  = N_ELEM * WORD_BITS;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = (N_ELEM + 1) * WORD_BITS;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam int COF_STAGES  = 2;
	localparam int DET_STAGES  = 3;
	localparam int DIV_STAGES  = Q_W + 3;
	localparam int COF_BASE    = 0;
	localparam int DET_BASE    = COF_BASE + COF_STAGES;
	localparam int DIV_BASE    = DET_BASE + DET_STAGES;
	localparam int PIPE_STAGES = DIV_BASE + DIV_STAGES;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [ADJ_W-1:0]     adj_t;
	typedef logic signed [DET_W-1:0]     det_t;

	// cofactor k = m[a]*m[b] - m[c]*m[d], row-major flat indices, already transposed
	localparam int ADJ_TAB [N_ELEM][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

endpackage

// ===== sv/matrix3x3_inverse_unit.sv =====
// Top level of the 3x3 fixed-point matrix inverse pipeline.
`timescale 1ns / 1ps
// Usage:
//  s_axis carries one whole matrix per transfer, nine signed Q16.16 elements
//  m00..m22 row-major. m_axis returns per matrix the nine inverse elements,
//  the determinant (both rounded to nearest, saturated) and, in tuser, a
//  singular flag; a singular matrix gives an all-zero tdata.
//  Throughput: one matrix per cycle while m_axis_tready stays high; the
//  depth is set by the divider, which resolves one quotient bit per stage
//  over 34 stages, after 2 cofactor, 3 determinant and 2 preparation
//  stages, with one output stage at the end.
//  Every stage has its own valid bit and advances when it is empty or the
//  next stage advances, so while m_axis is stalled new matrices keep filling
//  empty stages; s_axis_tready falls only once all 42 stages hold data.
//  Nothing is carried from one matrix to the next.
//  Reset (arst_n low) empties the pipeline at once; data in flight is lost.
module matrix3x3_inverse_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [mi3_pkg::IN_W-1:0]    s_axis_tdata,  // m00,m01,m02,m10,..,m22
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [mi3_pkg::OUT_W-1:0]   m_axis_tdata,  // inv00,..,inv22,det_value
	output logic [0:0]                  m_axis_tuser   // singular
);
	import mi3_pkg::*;

	logic [PIPE_STAGES-1:0] valid_q;
	logic [PIPE_STAGES-1:0] en;
	word_t                  m_in [N_ELEM];
	word_t                  row0_s2 [3];
	adj_t                   adj_s2 [N_ELEM];
	adj_t                   adj_s5 [N_ELEM];
	det_t                   det_s5;
	word_t                  inv_sl [N_ELEM];
	word_t                  detv_sl;
	logic                   sing_sl;

	assign en[PIPE_STAGES-1] = !valid_q[PIPE_STAGES-1] || m_axis_tready;
	for (genvar i = 0; i < PIPE_STAGES - 1; i++) begin : g_en
		assign en[i] = !valid_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) valid_q[0] <= s_axis_tvalid;
			for (int i = 1; i < PIPE_STAGES; i++)
				if (en[i]) valid_q[i] <= valid_q[i-1];
		end
	end

	always_comb begin
		for (int k = 0; k < N_ELEM; k++)
			m_in[k] = s_axis_tdata[k*WORD_BITS +: WORD_BITS];
	end

	mi3_cofactor u_cof (
		.clk     (clk),
		.en      (en[COF_BASE +: COF_STAGES]),
		.m       (m_in),
		.row0_s2 (row0_s2),
		.adj_s2  (adj_s2)
	);

	mi3_det u_det (
		.clk    (clk),
		.en     (en[DET_BASE +: DET_STAGES]),
		.row0   (row0_s2),
		.adj    (adj_s2),
		.adj_s5 (adj_s5),
		.det_s5 (det_s5)
	);

	mi3_divider u_div (
		.clk     (clk),
		.en      (en[DIV_BASE +: DIV_STAGES]),
		.adj     (adj_s5),
		.det     (det_s5),
		.inv_sl  (inv_sl),
		.detv_sl (detv_sl),
		.sing_sl (sing_sl)
	);

	assign s_axis_tready   = en[0];
	assign m_axis_tvalid   = valid_q[PIPE_STAGES-1];
	assign m_axis_tuser[0] = sing_sl;

	always_comb begin
		m_axis_tdata = '0;
		for (int k = 0; k < N_ELEM; k++)
			m_axis_tdata[k*WORD_BITS +: WORD_BITS] = inv_sl[k];
		m_axis_tdata[N_ELEM*WORD_BITS +: WORD_BITS] = detv_sl;
	end

endmodule

// ===== sv/mi3_cofactor.sv =====
// Cofactor stages: 2x2 products, then the exact adjugate.
`timescale 1ns / 1ps
module mi3_cofactor (
	input  logic                            clk,
	input  logic [mi3_pkg::COF_STAGES-1:0]  en,
	input  mi3_pkg::word_t                  m [mi3_pkg::N_ELEM],
	output mi3_pkg::word_t                  row0_s2 [3],
	output mi3_pkg::adj_t                   adj_s2 [mi3_pkg::N_ELEM]
);
	import mi3_pkg::*;

	logic signed [PROD_W-1:0] pa_s1 [N_ELEM];
	logic signed [PROD_W-1:0] pb_s1 [N_ELEM];
	word_t                    row0_s1 [3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < N_ELEM; k++) begin
				pa_s1[k] <= PROD_W'(m[ADJ_TAB[k][0]]) * PROD_W'(m[ADJ_TAB[k][1]]);
				pb_s1[k] <= PROD_W'(m[ADJ_TAB[k][2]]) * PROD_W'(m[ADJ_TAB[k][3]]);
			end
			for (int j = 0; j < 3; j++) row0_s1[j] <= m[j];
		end
		if (en[1]) begin
			for (int k = 0; k < N_ELEM; k++)
				adj_s2[k] <= ADJ_W'(pa_s1[k]) - ADJ_W'(pb_s1[k]);
			row0_s2 <= row0_s1;
		end
	end

endmodule

// ===== sv/mi3_det.sv =====
// Determinant stages: split products along row 0, limb sums, final sum.
`timescale 1ns / 1ps
module mi3_det (
	input  logic                            clk,
	input  logic [mi3_pkg::DET_STAGES-1:0]  en,
	input  mi3_pkg::word_t                  row0 [3],
	input  mi3_pkg::adj_t                   adj [mi3_pkg::N_ELEM],
	output mi3_pkg::adj_t                   adj_s5 [mi3_pkg::N_ELEM],
	output mi3_pkg::det_t                   det_s5
);
	import mi3_pkg::*;

	logic signed [PP_W-1:0] plo_s3 [3];
	logic signed [PP_W-1:0] phi_s3 [3];
	adj_t                   adj_s3 [N_ELEM];
	det_t                   term_s4 [3];
	adj_t                   adj_s4 [N_ELEM];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			// row 0 times column 0 of the adjugate, adjugate cut into two limbs
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= PP_W'(row0[j]) *
					PP_W'($signed({1'b0, adj[3*j][LO_W-1:0]}));
				phi_s3[j] <= PP_W'(row0[j]) * PP_W'($signed(adj[3*j][ADJ_W-1:LO_W]));
			end
			adj_s3 <= adj;
		end
		if (en[1]) begin
			for (int j = 0; j < 3; j++)
				term_s4[j] <= (DET_W'(phi_s3[j]) <<< LO_W) + DET_W'(plo_s3[j]);
			adj_s4 <= adj_s3;
		end
		if (en[2]) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			adj_s5 <= adj_s4;
		end
	end

endmodule

// ===== sv/mi3_divider.sv =====
// Nine-lane pipelined restoring divider with rounding and saturation, plus det output.
`timescale 1ns / 1ps
module mi3_divider (
	input  logic                            clk,
	input  logic [mi3_pkg::DIV_STAGES-1:0]  en,
	input  mi3_pkg::adj_t                   adj [mi3_pkg::N_ELEM],
	input  mi3_pkg::det_t                   det,
	output mi3_pkg::word_t                  inv_sl [mi3_pkg::N_ELEM],
	output mi3_pkg::word_t                  detv_sl,
	output logic                            sing_sl
);
	import mi3_pkg::*;

	function automatic word_t sat_word(input logic [DMAG_W:0] mag, input logic neg);
		logic [DMAG_W:0] lim;
		logic [DMAG_W:0] v;
		lim = (DMAG_W+1)'(1) << (WORD_BITS - 1);
		if (!neg) lim = lim - (DMAG_W+1)'(1);
		v = (mag > lim) ? lim : mag;
		if (neg) v = -v;
		return word_t'(v[WORD_BITS-1:0]);
	endfunction

	// prep stage
	logic [NUM_W-1:0]  num_s6 [N_ELEM];
	logic              neg_s6 [N_ELEM];
	logic [DMAG_W-1:0] dmag_s6;
	logic              detneg_s6;
	logic              sing_s6;

	// index 0 is the overflow-check stage, index i+1 follows quotient step i
	logic [NUM_W-1:0]  rem_sq  [Q_W+1][N_ELEM];
	logic [Q_W-1:0]    quo_sq  [Q_W+1][N_ELEM];
	logic              over_sq [Q_W+1][N_ELEM];
	logic              neg_sq  [Q_W+1][N_ELEM];
	logic [DMAG_W-1:0] dmag_sq [Q_W+1];
	logic              sing_sq [Q_W+1];
	word_t             detv_sq [Q_W+1];

	logic [CMP_W-1:0]  dsh    [Q_W];
	logic              ge     [Q_W][N_ELEM];
	logic [NUM_W-1:0]  rem_nx [Q_W][N_ELEM];
	logic [Q_W-1:0]    quo_nx [Q_W][N_ELEM];
	logic [DMAG_W:0]   rnd_d;
	logic [Q_W:0]      rnd_q [N_ELEM];

	always_comb begin
		for (int i = 0; i < Q_W; i++) begin
			dsh[i] = CMP_W'(dmag_sq[i]) << (Q_W - 1 - i);
			for (int k = 0; k < N_ELEM; k++) begin
				ge[i][k]     = CMP_W'(rem_sq[i][k]) >= dsh[i];
				rem_nx[i][k] = ge[i][k] ? NUM_W'(CMP_W'(rem_sq[i][k]) - dsh[i])
				                        : rem_sq[i][k];
				quo_nx[i][k] = quo_sq[i][k] | (Q_W'(ge[i][k]) << (Q_W - 1 - i));
			end
		end
		rnd_d = ((DMAG_W+1)'(dmag_s6) + ((DMAG_W+1)'(1) << (2*FRAC_BITS - 1)))
		        >> (2*FRAC_BITS);
		// floor(2N/D) rounded: odd bit means remainder at least half
		for (int k = 0; k < N_ELEM; k++)
			rnd_q[k] = ((Q_W+1)'(quo_sq[Q_W][k]) + (Q_W+1)'(1)) >> 1;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < N_ELEM; k++) begin
				num_s6[k] <= {(adj[k] < 0) ? AMAG_W'(-adj[k]) : AMAG_W'(adj[k]),
				              (2*FRAC_BITS+1)'(0)};
				neg_s6[k] <= (adj[k] < 0) ^ (det < 0);
			end
			dmag_s6   <= (det < 0) ? DMAG_W'(-det) : DMAG_W'(det);
			detneg_s6 <= det < 0;
			sing_s6   <= det == '0;
		end
		if (en[1]) begin
			for (int k = 0; k < N_ELEM; k++) begin
				rem_sq[0][k]  <= num_s6[k];
				quo_sq[0][k]  <= '0;
				over_sq[0][k] <= CMP_W'(num_s6[k]) >= (CMP_W'(dmag_s6) << Q_W);
				neg_sq[0][k]  <= neg_s6[k];
			end
			dmag_sq[0] <= dmag_s6;
			sing_sq[0] <= sing_s6;
			detv_sq[0] <= sat_word(rnd_d, detneg_s6);
		end
		for (int i = 0; i < Q_W; i++) begin
			if (en[2+i]) begin
				rem_sq[i+1]  <= rem_nx[i];
				quo_sq[i+1]  <= quo_nx[i];
				over_sq[i+1] <= over_sq[i];
				neg_sq[i+1]  <= neg_sq[i];
				dmag_sq[i+1] <= dmag_sq[i];
				sing_sq[i+1] <= sing_sq[i];
				detv_sq[i+1] <= detv_sq[i];
			end
		end
		if (en[Q_W+2]) begin
			for (int k = 0; k < N_ELEM; k++)
				inv_sl[k] <= sing_sq[Q_W] ? '0 :
					sat_word(over_sq[Q_W][k] ? '1 : (DMAG_W+1)'(rnd_q[k]),
					         neg_sq[Q_W][k]);
			detv_sl <= detv_sq[Q_W];
			sing_sl <= sing_sq[Q_W];
		end
	end

endmodule

// ===== sv/mi3_checker.sv =====
// Port-level checks for the matrix inverse unit, bound to the top level.
`timescale 1ns / 1ps
module mi3_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [mi3_pkg::OUT_W-1:0]   m_axis_tdata,
	input logic [0:0]                  m_axis_tuser
);
	import mi3_pkg::*;

	// pipeline empty once reset has been seen at an edge
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("m_axis_tvalid high during reset");

	// input only backs up when every stage is full and the output is stalled
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("s_axis_tready low with room in the pipeline");

	// a singular matrix returns an all-zero result
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("singular result with non-zero data");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

endmodule

bind matrix3x3_inverse_unit mi3_checker u_mi3_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== tb/matrix3x3_inverse_unit_tb.sv =====
// Self-checking testbench for the 3x3 fixed-point matrix inverse unit.
`timescale 1ns / 1ps
module matrix3x3_inverse_unit_tb;
	import mi3_pkg::*;

	localparam int ONE        = 32'h0001_0000;
	localparam int N_RANDOM   = 1540;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		word_t inv [N_ELEM];
		word_t det;
		logic  sing;
	} inverse_t;

	typedef logic signed [127:0] wide_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic [0:0]        m_axis_tuser;

	logic [IN_W-1:0] matrix_q [$];
	inverse_t        inverse_q [$];
	int              gap_left;
	int              stall_left;
	bit              load_done;
	int              n_errors;
	int              n_results;
	int              n_singular;
	int              idle_cycles;

	matrix3x3_inverse_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// num/den rounded to nearest, ties away from zero, saturated to a word
	function automatic word_t round_sat(wide_t num, wide_t den);
		logic        neg;
		logic [127:0] an, ad, q, r, lim;
		begin
			neg = num[127] ^ den[127];
			an  = num[127] ? -num : num;
			ad  = den[127] ? -den : den;
			q   = an / ad;
			r   = an % ad;
			if ((r << 1) >= ad)
				q = q + 1;
			lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
			if (q > lim)
				q = lim;
			return neg ? word_t'(-q[31:0]) : word_t'(q[31:0]);
		end
	endfunction

	function automatic inverse_t invert(logic [IN_W-1:0] d);
		wide_t    m [N_ELEM];
		wide_t    adj [N_ELEM];
		wide_t    det;
		inverse_t res;
		begin
			for (int k = 0; k < N_ELEM; k++)
				m[k] = wide_t'($signed(d[WORD_BITS*k +: WORD_BITS]));
			for (int k = 0; k < N_ELEM; k++)
				adj[k] = m[ADJ_TAB[k][0]] * m[ADJ_TAB[k][1]]
					- m[ADJ_TAB[k][2]] * m[ADJ_TAB[k][3]];
			det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
			res.sing = (det == 0);
			for (int k = 0; k < N_ELEM; k++)
				res.inv[k] = res.sing ? '0 : round_sat(adj[k] <<< (2 * FRAC_BITS), det);
			res.det = res.sing ? '0 : round_sat(det, wide_t'(1) <<< (2 * FRAC_BITS));
			return res;
		end
	endfunction

	function automatic logic [IN_W-1:0] pack(word_t e [N_ELEM]);
		logic [IN_W-1:0] d;
		begin
			d = '0;
			for (int k = 0; k < N_ELEM; k++)
				d[WORD_BITS*k +: WORD_BITS] = e[k];
			return d;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		begin
			r = $urandom_range(0, 99);
			if (r < 60)
				return 0;
			else if (r < 93)
				return $urandom_range(1, 3);
			return $urandom_range(10, 40);
		end
	endfunction

	task automatic report(string what, int idx, int got, int want);
		begin
			$display("mismatch on result %0d: %s got %08h expected %08h",
				n_results, what, got, want);
			n_errors++;
		end
	endtask

	// stimulus
	initial begin
		word_t e [N_ELEM];
		int    kind;
		int    src;
		word_t lim;
		load_done = 0;
		// identity, zero, diagonal ones of extreme values
		e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};                 matrix_q.push_back(pack(e));
		e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                       matrix_q.push_back(pack(e));
		e = '{32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff};
		matrix_q.push_back(pack(e));
		e = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
		matrix_q.push_back(pack(e));
		// tiny determinant drives the inverse into saturation both ways
		e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                       matrix_q.push_back(pack(e));
		e = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};                      matrix_q.push_back(pack(e));
		// determinant of exactly one half lsb: tie rounds away from zero
		e = '{32'h8000, 0, 0, 0, ONE, 0, 0, 0, 1};              matrix_q.push_back(pack(e));
		e = '{-32'sh8000, 0, 0, 0, ONE, 0, 0, 0, 1};            matrix_q.push_back(pack(e));
		// all-equal elements (singular), and a nonsingular mix of both extremes
		e = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		matrix_q.push_back(pack(e));
		e = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
		matrix_q.push_back(pack(e));
		e = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
		matrix_q.push_back(pack(e));
		// permutation with negative determinant, and a circulant with 2 on the diagonal
		e = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE};                 matrix_q.push_back(pack(e));
		e = '{2*ONE, ONE, 0, 0, 2*ONE, ONE, ONE, 0, 2*ONE};    matrix_q.push_back(pack(e));
		// rank two: third row is the sum of the first two
		e = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 5*ONE, 7*ONE, 9*ONE};
		matrix_q.push_back(pack(e));

		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(0, 9);
			lim  = (kind < 4) ? word_t'($urandom_range(1, 8) * ONE) : 32'h7fffffff;
			for (int k = 0; k < N_ELEM; k++) begin
				if (kind < 4)
					e[k] = word_t'($urandom_range(0, 2 * lim)) - lim;
				else
					e[k] = word_t'($urandom());
			end
			// some singular ones: repeated or zero row
			src = $urandom_range(0, 1) * 3;
			if (kind == 8)
				for (int k = 0; k < 3; k++)
					e[6 + k] = e[src + k];
			else if (kind == 9)
				for (int k = 0; k < 3; k++)
					e[3 + k] = 0;
			matrix_q.push_back(pack(e));
		end
		load_done = 1;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver: sender side and receiver back-pressure, changed on falling edges
	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		gap_left      = 0;
		stall_left    = 0;
	end

	bit sent;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || sent) begin
				if (gap_left > 0) begin
					s_axis_tvalid <= 1'b0;
					gap_left--;
				end else if (load_done && matrix_q.size() > 0) begin
					s_axis_tdata  <= matrix_q.pop_front();
					s_axis_tvalid <= 1'b1;
					gap_left = pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// monitor: takes both transfers at the rising edge
	always @(posedge clk) begin
		inverse_t want;
		sent <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (s_axis_tvalid && s_axis_tready)
				inverse_q.push_back(invert(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (inverse_q.size() == 0) begin
					report("unexpected transfer", 0, 0, 0);
				end else begin
					want = inverse_q.pop_front();
					for (int k = 0; k < N_ELEM; k++)
						if (m_axis_tdata[WORD_BITS*k +: WORD_BITS] !== want.inv[k])
							report($sformatf("inv%0d%0d", k / 3, k % 3), k,
								m_axis_tdata[WORD_BITS*k +: WORD_BITS], want.inv[k]);
					if (m_axis_tdata[WORD_BITS*N_ELEM +: WORD_BITS] !== want.det)
						report("det_value", 9,
							m_axis_tdata[WORD_BITS*N_ELEM +: WORD_BITS], want.det);
					if (m_axis_tuser[0] !== want.sing)
						report("singular", 10, m_axis_tuser[0], want.sing);
					if (want.sing)
						n_singular++;
				end
				n_results++;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		n_errors    = 0;
		n_results   = 0;
		n_singular  = 0;
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("no transfer for %0d cycles, %0d results pending",
				idle_cycles, inverse_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		wait (load_done);
		wait (matrix_q.size() == 0);
		@(posedge clk);
		wait (!s_axis_tvalid && inverse_q.size() == 0);
		repeat (60) @(posedge clk);
		if (inverse_q.size() != 0)
			report("results left over", 0, inverse_q.size(), 0);
		$display("checked %0d inverses, %0d of them singular, with random stalls on both sides",
			n_results, n_singular);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
